// ----- sv/rcbm_pkg.sv -----
// rcbm_pkg: shared types and constants of the cartridge bank mapper
`timescale 1ns / 1ps

package rcbm_pkg;

  // image size as address bits, and the widest image address the mapper forms
  localparam int IMAGE_ADDR_BITS_DEF = 17;
  localparam int MAX_ADDR_BITS       = 22;
  localparam int LOAD_ADDR_BITS      = 17;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register map: index taken from paddr[2]
  localparam logic REG_MAPPER_MODE = 1'b0;

  // bus window limits and fields of the bus address
  localparam logic [15:0] WIN_LOW     = 16'h4000;
  localparam logic [15:0] WIN_HIGH    = 16'hBFFF;
  localparam logic [2:0]  SEG8K_FIRST = 3'd2;

  // switch addresses
  localparam logic [15:0] SW_5000 = 16'h5000;
  localparam logic [15:0] SW_6000 = 16'h6000;
  localparam logic [15:0] SW_6800 = 16'h6800;
  localparam logic [15:0] SW_7000 = 16'h7000;
  localparam logic [15:0] SW_77FF = 16'h77FF;
  localparam logic [15:0] SW_7800 = 16'h7800;
  localparam logic [15:0] SW_8000 = 16'h8000;
  localparam logic [15:0] SW_9000 = 16'h9000;
  localparam logic [15:0] SW_A000 = 16'hA000;
  localparam logic [15:0] SW_B000 = 16'hB000;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_PLAIN32 = 3'd0,
    MODE_LINEAR48 = 3'd1,
    MODE_SCC8K    = 3'd2,
    MODE_KON8K    = 3'd3,
    MODE_ASCII8K  = 3'd4,
    MODE_ASCII16K = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_READ = 2'd1,
    CMD_LOAD = 2'd2
  } cmd_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    cmd_t                     kind;
    logic [MAX_ADDR_BITS-1:0] addr;
    logic [7:0]               data;
  } entry_t;

endpackage

// ----- sv/rcbm_front.sv -----
// rcbm_front: accepts bus transactions, holds mode and bank registers, classifies
`timescale 1ns / 1ps

module rcbm_front
  import rcbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  // transaction fields
  input  logic         accept,
  input  logic [1:0]   opcode,
  input  logic         slot_selected,
  input  logic [15:0]  bus_address,
  input  logic [7:0]   bus_write_data,
  input  logic [16:0]  image_address,
  output entry_t       entry
);

  mode_t      mapper_mode;
  logic [7:0] bank [0:3];

  logic       in_std;
  logic [2:0] seg_off;
  logic [1:0] seg8k;
  logic       sw_hit;
  logic [1:0] sw_tgt;

  // register read back
  assign prdata = (paddr[2] == REG_MAPPER_MODE) ? {29'b0, mapper_mode} : 32'b0;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_mode <= MODE_PLAIN32;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAPPER_MODE)) begin
      mapper_mode <= mode_t'(pwdata[2:0]);
    end
  end

  // address decode helpers
  assign in_std  = (bus_address >= WIN_LOW) && (bus_address <= WIN_HIGH);
  assign seg_off = bus_address[15:13] - SEG8K_FIRST;
  assign seg8k   = seg_off[1:0];

  // switch address decode per mode
  always_comb begin
    sw_hit = 1'b0;
    sw_tgt = 2'd0;
    case (mapper_mode)
      MODE_SCC8K: begin
        case (bus_address)
          SW_5000: begin sw_hit = 1'b1; sw_tgt = 2'd0; end
          SW_7000: begin sw_hit = 1'b1; sw_tgt = 2'd1; end
          SW_9000: begin sw_hit = 1'b1; sw_tgt = 2'd2; end
          SW_B000: begin sw_hit = 1'b1; sw_tgt = 2'd3; end
          default: sw_hit = 1'b0;
        endcase
      end
      MODE_KON8K: begin
        case (bus_address)
          SW_6000: begin sw_hit = 1'b1; sw_tgt = 2'd1; end
          SW_8000: begin sw_hit = 1'b1; sw_tgt = 2'd2; end
          SW_A000: begin sw_hit = 1'b1; sw_tgt = 2'd3; end
          default: sw_hit = 1'b0;
        endcase
      end
      MODE_ASCII8K: begin
        case (bus_address)
          SW_6000: begin sw_hit = 1'b1; sw_tgt = 2'd0; end
          SW_6800: begin sw_hit = 1'b1; sw_tgt = 2'd1; end
          SW_7000: begin sw_hit = 1'b1; sw_tgt = 2'd2; end
          SW_7800: begin sw_hit = 1'b1; sw_tgt = 2'd3; end
          default: sw_hit = 1'b0;
        endcase
      end
      MODE_ASCII16K: begin
        case (bus_address)
          SW_6000: begin sw_hit = 1'b1; sw_tgt = 2'd0; end
          SW_7000, SW_77FF: begin sw_hit = 1'b1; sw_tgt = 2'd1; end
          default: sw_hit = 1'b0;
        endcase
      end
      default: sw_hit = 1'b0;
    endcase
  end

  // bank registers, written by bus writes on a switch address
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        bank[i] <= 8'(i);
      end
    end else if (accept && (op_t'(opcode) == OP_WRITE) && slot_selected && sw_hit) begin
      bank[sw_tgt] <= bus_write_data;
    end
  end

  // classify the transaction and form the image address
  always_comb begin
    entry.kind = CMD_NONE;
    entry.addr = '0;
    entry.data = bus_write_data;
    case (op_t'(opcode))
      OP_READ: begin
        if (slot_selected) begin
          case (mapper_mode)
            MODE_PLAIN32: begin
              if (in_std) begin
                entry.kind = CMD_READ;
                entry.addr = {6'b0, bus_address - WIN_LOW};
              end
            end
            MODE_LINEAR48: begin
              if (bus_address <= WIN_HIGH) begin
                entry.kind = CMD_READ;
                entry.addr = {6'b0, bus_address};
              end
            end
            MODE_SCC8K, MODE_KON8K, MODE_ASCII8K: begin
              if (in_std) begin
                entry.kind = CMD_READ;
                entry.addr = {1'b0, bank[seg8k], bus_address[12:0]};
              end
            end
            MODE_ASCII16K: begin
              if (in_std) begin
                entry.kind = CMD_READ;
                entry.addr = {bank[{1'b0, bus_address[15]}], bus_address[13:0]};
              end
            end
            default: entry.kind = CMD_NONE;
          endcase
        end
      end
      OP_LOAD: begin
        entry.kind = CMD_LOAD;
        entry.addr = {{(MAX_ADDR_BITS - LOAD_ADDR_BITS){1'b0}}, image_address};
      end
      default: entry.kind = CMD_NONE;
    endcase
  end

endmodule

// ----- sv/rcbm_queue.sv -----
// rcbm_queue: short command queue between the front and the back
`timescale 1ns / 1ps

module rcbm_queue
  import rcbm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  entry_t             slots [0:Q_DEPTH-1];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rcbm_back.sv -----
// rcbm_back: image memory and result register
`timescale 1ns / 1ps

module rcbm_back
  import rcbm_pkg::*;
#(
  parameter int IMAGE_ADDR_BITS = IMAGE_ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       drive_enable
);

  logic [7:0]                 image_mem [0:(2**IMAGE_ADDR_BITS)-1];
  logic [IMAGE_ADDR_BITS-1:0] mem_addr;
  logic [7:0]                 rdata;

  // issue when the result register is free or being emptied
  assign pop      = head_valid && (!out_valid || out_ready);
  assign mem_addr = head_entry.addr[IMAGE_ADDR_BITS-1:0];

  // image memory: load writes, bus reads
  always_ff @(posedge clk) begin
    if (pop && (head_entry.kind == CMD_LOAD)) begin
      image_mem[mem_addr] <= head_entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head_entry.kind == CMD_READ)) begin
      rdata <= image_mem[mem_addr];
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      drive_enable <= 1'b0;
    end else if (pop) begin
      out_valid    <= 1'b1;
      drive_enable <= (head_entry.kind == CMD_READ);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign read_data = drive_enable ? rdata : 8'h00;

endmodule

// ----- sv/rom_cartridge_bank_mapper_top.sv -----
// Cartridge slot bank mapper: six mapping modes over a loadable ROM image.
//
// Input channel (in_valid/in_ready) carries one transaction each: a bus read,
// a bus write, or one image byte load. Every transaction yields exactly one
// transaction on the output channel (out_valid/out_ready): read_data and
// drive_enable, both zero unless a selected read falls inside the mode's window.
// The APB port holds mapper_mode at address 0; write it only while idle.
// An accepted transaction is written into the command queue and then passes
// through the result register before out_valid rises.
// Throughput: one transaction per cycle while the output is not held, set by the
// single image memory port that serves one read or load per cycle; the two-entry
// command queue takes up to two more transactions while the output is held.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready falls once both queue entries are taken.
// Reset (synchronous, rst high) sets mapper_mode to plain 32K, the bank
// registers to 0,1,2,3 and empties the queue; the image memory is not cleared
// and must be loaded before it is read.
`timescale 1ns / 1ps

module rom_cartridge_bank_mapper_top
  import rcbm_pkg::*;
#(
  parameter int IMAGE_ADDR_BITS = IMAGE_ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input channel
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   opcode,
  input  logic         slot_selected,
  input  logic [15:0]  bus_address,
  input  logic [7:0]   bus_write_data,
  input  logic [16:0]  image_address,
  // output channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   read_data,
  output logic         drive_enable
);

  logic   accept;
  logic   q_full;
  logic   q_pop;
  logic   head_valid;
  entry_t front_entry;
  entry_t head_entry;

  assign pready   = 1'b1;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: registers and classification
  rcbm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .accept         (accept),
    .opcode         (opcode),
    .slot_selected  (slot_selected),
    .bus_address    (bus_address),
    .bus_write_data (bus_write_data),
    .image_address  (image_address),
    .entry          (front_entry)
  );

  // command queue
  rcbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // back: image memory and result
  rcbm_back #(
    .IMAGE_ADDR_BITS (IMAGE_ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .drive_enable (drive_enable)
  );

endmodule

// ----- sv/rcbm_checker.sv -----
// rcbm_checker: port-level assertions for the bank mapper, bound to the top level
`timescale 1ns / 1ps

module rcbm_checker (
  input logic        clk,
  input logic        rst,
  input logic [31:0] prdata,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic        drive_enable
);

  // no result is offered in the cycle after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // data is zero whenever the block does not drive the bus
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive_enable) |-> (read_data == 8'h00))
    else $error("read_data not zero without drive_enable");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(read_data) && $stable(drive_enable)))
    else $error("stalled result changed");

  // mode register reads back only its three bits
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    prdata[31:3] == 29'b0)
    else $error("prdata upper bits set");

endmodule

bind rom_cartridge_bank_mapper_top rcbm_checker u_rcbm_checker (
  .clk          (clk),
  .rst          (rst),
  .prdata       (prdata),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .drive_enable (drive_enable)
);

// ----- test/testbench.sv -----
// testbench: randomised and directed checks of the cartridge bank mapper against a predictor
`timescale 1ns / 1ps

module testbench;
  import rcbm_pkg::*;

  localparam int IMG_BITS = IMAGE_ADDR_BITS_DEF;
  localparam int IMG_SIZE = 1 << IMG_BITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 50;

  // mode codes with no mapping, and the unused register index
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic       REG_SPARE   = 1'b1;

  typedef struct packed {
    op_t         op;
    logic        sel;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [16:0] img_addr;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       drive;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [1:0]  opcode = '0;
  logic        slot_selected = 1'b0;
  logic [15:0] bus_address = '0;
  logic [7:0]  bus_write_data = '0;
  logic [16:0] image_address = '0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [7:0]  read_data;
  wire         drive_enable;

  // transactions waiting to be driven, and answers still owed by the block
  access_t access_q[$];
  answer_t answers_due[$];

  // predictor state
  logic [2:0]      cfg_mode = MODE_PLAIN32;
  logic [3:0][7:0] shadow_bank = {8'd3, 8'd2, 8'd1, 8'd0};
  logic [7:0]      shadow_image [IMG_SIZE];

  // stimulus planning state, kept ahead of the predictor
  logic [3:0][7:0] plan_bank = {8'd3, 8'd2, 8'd1, 8'd0};
  bit              image_loaded [IMG_SIZE];

  access_t driven;
  answer_t due;
  bit      in_fire = 1'b0;
  bit      quiet = 1'b0;
  int      in_gap = 0;
  int      hold_left = 0;
  int      cycle_count = 0;
  int      errors = 0;

  rom_cartridge_bank_mapper_top dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // image position seen by a bus read, and whether the mode answers it at all
  function automatic bit window_to_image(input logic [2:0] mode, input logic [3:0][7:0] bk,
                                         input logic [15:0] a, output logic [IMG_BITS-1:0] ia);
    logic [31:0] full;
    logic [15:0] off;
    bit          in_win;
    bit          hit;
    in_win = (a >= WIN_LOW) && (a <= WIN_HIGH);
    off = a - WIN_LOW;
    full = '0;
    hit = 1'b0;
    case (mode)
      MODE_PLAIN32: begin
        full = {16'b0, off};
        hit = in_win;
      end
      MODE_LINEAR48: begin
        full = {16'b0, a};
        hit = (a <= WIN_HIGH);
      end
      MODE_SCC8K, MODE_KON8K, MODE_ASCII8K: begin
        full = {11'b0, bk[off[14:13]], a[12:0]};
        hit = in_win;
      end
      MODE_ASCII16K: begin
        full = {10'b0, bk[a[15]], a[13:0]};
        hit = in_win;
      end
      default: hit = 1'b0;
    endcase
    ia = full[IMG_BITS-1:0];
    return hit;
  endfunction

  // bank register set by a write, -1 when the address is not a switch address
  function automatic int switch_bank(input logic [2:0] mode, input logic [15:0] a);
    case (mode)
      MODE_SCC8K:
        case (a)
          SW_5000: return 0;
          SW_7000: return 1;
          SW_9000: return 2;
          SW_B000: return 3;
          default: return -1;
        endcase
      MODE_KON8K:
        case (a)
          SW_6000: return 1;
          SW_8000: return 2;
          SW_A000: return 3;
          default: return -1;
        endcase
      MODE_ASCII8K:
        case (a)
          SW_6000: return 0;
          SW_6800: return 1;
          SW_7000: return 2;
          SW_7800: return 3;
          default: return -1;
        endcase
      MODE_ASCII16K:
        case (a)
          SW_6000: return 0;
          SW_7000, SW_77FF: return 1;
          default: return -1;
        endcase
      default: return -1;
    endcase
  endfunction

  // apply one accepted transaction to the predictor and record the answer owed
  task automatic predict_answer(input access_t t);
    answer_t             r;
    logic [IMG_BITS-1:0] ia;
    bit                  hit;
    int                  tgt;
    r.rdata = 8'h00;
    r.drive = 1'b0;
    hit = window_to_image(cfg_mode, shadow_bank, t.addr, ia);
    case (t.op)
      OP_READ:
        if (t.sel && hit) begin
          r.rdata = shadow_image[ia];
          r.drive = 1'b1;
        end
      OP_WRITE:
        if (t.sel) begin
          tgt = switch_bank(cfg_mode, t.addr);
          if (tgt >= 0) shadow_bank[tgt] = t.data;
        end
      OP_LOAD: shadow_image[t.img_addr[IMG_BITS-1:0]] = t.data;
      default: ;
    endcase
    answers_due.push_back(r);
  endtask

  function automatic access_t mk(input op_t op, input logic sel, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [16:0] img_addr);
    access_t t;
    t.op = op;
    t.sel = sel;
    t.addr = addr;
    t.data = data;
    t.img_addr = img_addr;
    return t;
  endfunction

  // queue a transaction; a read of a byte never loaded gets a load in front of it
  task automatic queue_access(input access_t t);
    logic [IMG_BITS-1:0] ia;
    bit                  hit;
    int                  tgt;
    hit = window_to_image(cfg_mode, plan_bank, t.addr, ia);
    if (t.op == OP_READ && t.sel && hit && !image_loaded[ia]) begin
      access_q.push_back(mk(OP_LOAD, 1'($urandom_range(1)), 16'($urandom), 8'($urandom),
                            17'(ia)));
      image_loaded[ia] = 1'b1;
    end
    if (t.op == OP_WRITE && t.sel) begin
      tgt = switch_bank(cfg_mode, t.addr);
      if (tgt >= 0) plan_bank[tgt] = t.data;
    end
    if (t.op == OP_LOAD) image_loaded[t.img_addr[IMG_BITS-1:0]] = 1'b1;
    access_q.push_back(t);
  endtask

  // random transaction: mostly window reads and switch writes, some loads and noise
  function automatic access_t random_access();
    access_t t;
    int      r;
    t = mk(OP_READ, 1'($urandom_range(99) < 92), 16'($urandom), 8'($urandom),
           17'($urandom));
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(9))
        0: ;
        1:
          case ($urandom_range(5))
            0: t.addr = 16'h0000;
            1: t.addr = 16'h3FFF;
            2: t.addr = WIN_LOW;
            3: t.addr = WIN_HIGH;
            4: t.addr = 16'hC000;
            default: t.addr = 16'hFFFF;
          endcase
        default: t.addr = 16'($urandom_range(WIN_HIGH, WIN_LOW));
      endcase
    end else if (r < 65) begin
      t.op = OP_WRITE;
      if ($urandom_range(99) < 65)
        case ($urandom_range(10))
          0: t.addr = SW_5000;
          1: t.addr = SW_6000;
          2: t.addr = SW_6800;
          3: t.addr = SW_7000;
          4: t.addr = SW_77FF;
          5: t.addr = SW_7800;
          6: t.addr = SW_8000;
          7: t.addr = SW_9000;
          8: t.addr = SW_A000;
          default: t.addr = SW_B000;
        endcase
    end else if (r < 93) begin
      t.op = OP_LOAD;
    end else begin
      t.op = OP_NOP;
    end
    return t;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  task automatic apb_write(input logic idx, input logic [2:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {29'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAPPER_MODE) cfg_mode = val;
  endtask

  task automatic apb_check(input logic [2:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_MAPPER_MODE, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {29'b0, want}) begin
      $display("%0t: mapper_mode readback expected %08h got %08h", $time, {29'b0, want},
               prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every queued transaction has been answered, then let the pipe settle
  task automatic drain();
    while (access_q.size() != 0 || in_valid || answers_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (access_q.size() > 0) begin
        driven = access_q.pop_front();
        opcode <= driven.op;
        slot_selected <= driven.sel;
        bus_address <= driven.addr;
        bus_write_data <= driven.data;
        image_address <= driven.img_addr;
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && !quiet && $urandom_range(99) >= 70) hold_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on input transactions, compare output transactions
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      in_fire = !rst && in_valid && in_ready;
      if (in_fire) predict_answer(driven);
      if (!rst && out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer read_data %02h drive_enable %b", $time,
                   read_data, drive_enable);
          errors++;
        end else begin
          due = answers_due.pop_front();
          if (read_data !== due.rdata) begin
            $display("%0t: read_data expected %02h got %02h", $time, due.rdata, read_data);
            errors++;
          end
          if (drive_enable !== due.drive) begin
            $display("%0t: drive_enable expected %b got %b", $time, due.drive, drive_enable);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [2:0] mode;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    apb_check(MODE_PLAIN32);

    // directed: plain 32K after reset, window edges, slot select, every opcode
    queue_access(mk(OP_LOAD, 1'b0, 16'h0000, 8'hA5, 17'h00000));
    queue_access(mk(OP_LOAD, 1'b1, 16'hFFFF, 8'h5A, 17'h1FFFF));
    queue_access(mk(OP_LOAD, 1'b1, 16'h4000, 8'hFF, 17'h07FFF));
    queue_access(mk(OP_READ, 1'b1, WIN_LOW, 8'h00, 17'h00000));
    queue_access(mk(OP_READ, 1'b1, WIN_HIGH, 8'hFF, 17'h1FFFF));
    queue_access(mk(OP_READ, 1'b0, WIN_LOW, 8'h00, 17'h00000));
    queue_access(mk(OP_READ, 1'b1, 16'h3FFF, 8'h00, 17'h00000));
    queue_access(mk(OP_READ, 1'b1, 16'hC000, 8'h00, 17'h00000));
    queue_access(mk(OP_READ, 1'b1, 16'hFFFF, 8'h00, 17'h00000));
    queue_access(mk(OP_READ, 1'b1, 16'h0000, 8'h00, 17'h00000));
    queue_access(mk(OP_WRITE, 1'b1, SW_6000, 8'hFF, 17'h00000));
    queue_access(mk(OP_WRITE, 1'b0, 16'h0000, 8'h00, 17'h1FFFF));
    queue_access(mk(OP_NOP, 1'b1, 16'hFFFF, 8'hFF, 17'h1FFFF));
    queue_access(mk(OP_READ, 1'b1, WIN_LOW, 8'h00, 17'h00000));
    drain();

    // random phases across every mode, banks carried over between them
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: mode = MODE_LINEAR48;
        1: mode = MODE_SCC8K;
        2: mode = MODE_KON8K;
        3: mode = MODE_ASCII8K;
        4: mode = MODE_ASCII16K;
        5: mode = MODE_SPARE7;
        6: mode = MODE_PLAIN32;
        7: mode = MODE_SCC8K;
        8: mode = MODE_SPARE6;
        default: mode = MODE_ASCII16K;
      endcase
      quiet = (p == 2 || p == 6);
      apb_write(REG_MAPPER_MODE, mode);
      if (p == 5) apb_write(REG_SPARE, 3'($urandom));
      apb_check(mode);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_access(random_access());
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
